[design/srsa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srsa_pkg
// Shared codes, widths and state type for the sample rate step adjuster.
// ----------------------------------------------------------------------------
package srsa_pkg;

    localparam int OP_W     = 3;
    localparam int MODE_W   = 4;
    localparam int BYTE_W   = 8;
    localparam int PERIOD_W = 19;

    // Step requests
    localparam logic [OP_W-1:0] OP_NONE = 3'd0;
    localparam logic [OP_W-1:0] OP_CINC = 3'd1;
    localparam logic [OP_W-1:0] OP_FINC = 3'd2;
    localparam logic [OP_W-1:0] OP_CDEC = 3'd3;
    localparam logic [OP_W-1:0] OP_FDEC = 3'd4;
    localparam logic [OP_W-1:0] OP_LOAD = 3'd5;

    // Sampling modes; codes above M_250K are carried through untouched
    localparam logic [MODE_W-1:0] M_DELAY = 4'd0;
    localparam logic [MODE_W-1:0] M_XY    = 4'd1;
    localparam logic [MODE_W-1:0] M_1M    = 4'd2;
    localparam logic [MODE_W-1:0] M_833K  = 4'd3;
    localparam logic [MODE_W-1:0] M_625K  = 4'd4;
    localparam logic [MODE_W-1:0] M_417K  = 4'd5;
    localparam logic [MODE_W-1:0] M_250K  = 4'd6;

    // Fixed-rate periods and delay-mode offsets, in device ticks
    localparam logic [PERIOD_W-1:0] P_1M      = 19'd5;
    localparam logic [PERIOD_W-1:0] P_833K    = 19'd6;
    localparam logic [PERIOD_W-1:0] P_625K    = 19'd8;
    localparam logic [PERIOD_W-1:0] P_417K    = 19'd12;
    localparam logic [PERIOD_W-1:0] P_250K    = 19'd20;
    localparam logic [PERIOD_W-1:0] P_BASE    = 19'd5;
    localparam logic [PERIOD_W-1:0] P_DLY_ADD = 19'd14;
    localparam logic [PERIOD_W-1:0] P_XY_ADD  = 19'd21;

    localparam logic [BYTE_W-1:0] BYTE_MAX   = 8'd255;
    localparam logic [BYTE_W-1:0] COARSE_LIM = 8'd128;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BYTE_W-1:0] high;
        logic [BYTE_W-1:0] low;
    } t_state;

    localparam t_state STATE_RESET = '{mode: M_DELAY, high: 8'd0, low: 8'd1};

endpackage
`default_nettype wire

[design/srsa_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srsa_step
// Next-state logic: applies one step request to mode and delay bytes.
// ----------------------------------------------------------------------------
module srsa_step (
    input  var srsa_pkg::t_state                 i_state,
    input  wire logic [srsa_pkg::OP_W-1:0]       i_opcode,
    input  wire logic [srsa_pkg::MODE_W-1:0]     i_load_mode,
    input  wire logic [srsa_pkg::BYTE_W-1:0]     i_load_high,
    input  wire logic [srsa_pkg::BYTE_W-1:0]     i_load_low,
    output var srsa_pkg::t_state                 o_state
);
    import srsa_pkg::*;

    logic [BYTE_W-1:0] w_inc_low;
    logic              w_coarse;
    t_state            w_inc;
    t_state            w_dec;

    assign w_inc_low = (i_opcode == OP_CINC) ? (i_state.low >> 1) : (i_state.low - 8'd1);
    assign w_coarse  = (i_opcode == OP_CDEC);

    // Increase: shorter delay, then step up through the fixed rates
    always_comb begin
        w_inc = i_state;
        case (i_state.mode)
            M_DELAY: begin
                w_inc.low = w_inc_low;
                if (w_inc_low == '0) begin
                    w_inc.low = BYTE_MAX;
                    if (i_state.high == '0) begin
                        w_inc.mode = M_250K;
                    end else begin
                        w_inc.high = i_state.high - 8'd1;
                    end
                end
            end
            M_XY: begin
                w_inc.low = w_inc_low;
                if (w_inc_low == '0) begin
                    // saturate at the shortest delay
                    if (i_state.high == '0) begin
                        w_inc.low = 8'd1;
                    end else begin
                        w_inc.low  = BYTE_MAX;
                        w_inc.high = i_state.high - 8'd1;
                    end
                end
            end
            M_833K: w_inc.mode = M_1M;
            M_625K: w_inc.mode = M_833K;
            M_417K: w_inc.mode = M_625K;
            M_250K: begin
                w_inc.mode = M_417K;
                w_inc.high = 8'd0;
                w_inc.low  = 8'd1;
            end
            default: w_inc = i_state;
        endcase
    end

    // Decrease: longer delay, fixed rates step down into delay mode
    always_comb begin
        w_dec = i_state;
        case (i_state.mode)
            M_DELAY, M_XY: begin
                if (w_coarse && i_state.low < COARSE_LIM) begin
                    w_dec.low = {i_state.low[BYTE_W-2:0], 1'b0};
                end else if (!w_coarse && i_state.low != BYTE_MAX) begin
                    w_dec.low = i_state.low + 8'd1;
                end else begin
                    w_dec.low = 8'd1;
                    if (i_state.high != BYTE_MAX) begin
                        w_dec.high = i_state.high + 8'd1;
                    end
                end
            end
            M_1M:   w_dec.mode = M_833K;
            M_833K: w_dec.mode = M_625K;
            M_625K: w_dec.mode = M_417K;
            M_417K: w_dec.mode = M_250K;
            M_250K: begin
                w_dec.mode = M_DELAY;
                w_dec.high = 8'd0;
                w_dec.low  = 8'd1;
            end
            default: w_dec = i_state;
        endcase
    end

    always_comb begin
        case (i_opcode)
            OP_CINC, OP_FINC: o_state = w_inc;
            OP_CDEC, OP_FDEC: o_state = w_dec;
            OP_LOAD: begin
                o_state.mode = i_load_mode;
                o_state.high = i_load_high;
                o_state.low  = i_load_low;
            end
            default: o_state = i_state;
        endcase
    end

endmodule
`default_nettype wire

[design/srsa_period.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srsa_period
// Sample period in device ticks for a given mode and delay pair.
// ----------------------------------------------------------------------------
module srsa_period (
    input  var srsa_pkg::t_state                 i_state,
    output logic [srsa_pkg::PERIOD_W-1:0]        o_period_ticks,
    output logic                                 o_mode_known
);
    import srsa_pkg::*;

    logic [BYTE_W-1:0]   w_hp;
    logic [BYTE_W:0]     w_hp_inc;
    logic [PERIOD_W-1:0] w_span;
    logic [PERIOD_W-1:0] w_hp_w;
    logic [PERIOD_W-1:0] w_base;

    // Low byte of zero counts as a full 256; high byte of zero then as 255
    assign w_hp     = (i_state.low == '0 && i_state.high == '0) ? BYTE_MAX : i_state.high;
    assign w_hp_inc = {1'b0, w_hp} + 9'd1;
    assign w_span   = (i_state.low == '0)
                    ? {2'b0, w_hp_inc, 8'd0}
                    : {3'b0, i_state.high, i_state.low};
    assign w_hp_w   = {11'd0, w_hp};

    // 5 + 7*span + 3*h; the shift by three may wrap, the difference does not
    assign w_base = P_BASE + ((w_span << 3) - w_span) + (w_hp_w << 1) + w_hp_w;

    always_comb begin
        o_mode_known = 1'b1;
        case (i_state.mode)
            M_DELAY: o_period_ticks = w_base + P_DLY_ADD;
            M_XY:    o_period_ticks = w_base + P_XY_ADD;
            M_1M:    o_period_ticks = P_1M;
            M_833K:  o_period_ticks = P_833K;
            M_625K:  o_period_ticks = P_625K;
            M_417K:  o_period_ticks = P_417K;
            M_250K:  o_period_ticks = P_250K;
            default: begin
                o_period_ticks = '0;
                o_mode_known   = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

[design/sample_rate_step_adjuster.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sample_rate_step_adjuster
// Steps the sampling mode and delay pair and reports the sample period.
// ----------------------------------------------------------------------------
// Every accepted request gives exactly one result, and a new request is taken
// every cycle while results drain.
// A request is held in an input register; the next-state logic and the
// period calculation (one multiply by seven as shift and subtract) sit
// between that register and the result register, and the state registers
// load in the same cycle as the result register, so back-to-back requests
// see each other's effect. Reset sets delay mode, high 0, low 1.
module sample_rate_step_adjuster (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [srsa_pkg::OP_W-1:0]         i_opcode,
    input  wire logic [srsa_pkg::MODE_W-1:0]       i_load_mode,
    input  wire logic [srsa_pkg::BYTE_W-1:0]       i_load_high,
    input  wire logic [srsa_pkg::BYTE_W-1:0]       i_load_low,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [srsa_pkg::MODE_W-1:0]            o_mode_now,
    output logic [srsa_pkg::BYTE_W-1:0]            o_high_now,
    output logic [srsa_pkg::BYTE_W-1:0]            o_low_now,
    output logic [srsa_pkg::PERIOD_W-1:0]          o_period_ticks,
    output logic                                   o_mode_known
);
    import srsa_pkg::*;

    logic                r_in_valid;
    logic [OP_W-1:0]     r_in_opcode;
    logic [MODE_W-1:0]   r_in_mode;
    logic [BYTE_W-1:0]   r_in_high;
    logic [BYTE_W-1:0]   r_in_low;

    t_state              r_state;
    t_state              n_state;

    logic                r_out_valid;
    t_state              r_out_state;
    logic [PERIOD_W-1:0] r_out_period;
    logic                r_out_known;

    logic [PERIOD_W-1:0] w_period;
    logic                w_known;
    logic                w_out_free;
    logic                w_fire;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_ready    = !r_in_valid || w_out_free;

    srsa_step u_step (
        .i_state     (r_state),
        .i_opcode    (r_in_opcode),
        .i_load_mode (r_in_mode),
        .i_load_high (r_in_high),
        .i_load_low  (r_in_low),
        .o_state     (n_state)
    );

    srsa_period u_period (
        .i_state        (n_state),
        .o_period_ticks (w_period),
        .o_mode_known   (w_known)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_opcode <= i_opcode;
            r_in_mode   <= i_load_mode;
            r_in_high   <= i_load_high;
            r_in_low    <= i_load_low;
        end
    end

    // State and result registers advance together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_fire) begin
            r_out_state  <= n_state;
            r_out_period <= w_period;
            r_out_known  <= w_known;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_mode_now     = r_out_state.mode;
    assign o_high_now     = r_out_state.high;
    assign o_low_now      = r_out_state.low;
    assign o_period_ticks = r_out_period;
    assign o_mode_known   = r_out_known;

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(r_state))
        else $error("state changed without a request");

    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (o_valid && o_mode_now == r_state.mode
                    && o_high_now == r_state.high && o_low_now == r_state.low))
        else $error("result does not match updated state");

    a_known_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_mode_known == (o_period_ticks != '0)))
        else $error("mode_known disagrees with period");

    a_known_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_mode_known == (o_mode_now <= M_250K)))
        else $error("mode_known disagrees with mode code");

endmodule
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives step requests into the sample rate step adjuster and checks every
// result against a cycle-free model of the mode and delay registers.
// ----------------------------------------------------------------------------
module testbench;

    import srsa_pkg::*;

    localparam int N_RANDOM     = 1925;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [BYTE_W-1:0]   high;
        logic [BYTE_W-1:0]   low;
        logic [PERIOD_W-1:0] period;
        logic                known;
    } t_rate_result;

    class rate_scoreboard;
        logic [MODE_W-1:0] mode;
        logic [BYTE_W-1:0] high;
        logic [BYTE_W-1:0] low;
        t_rate_result      expected_rates[$];
        int                errors;
        int                checked;

        function new();
            mode    = M_DELAY;
            high    = 8'd0;
            low     = 8'd1;
            errors  = 0;
            checked = 0;
        endfunction

        function int pending();
            return expected_rates.size();
        endfunction

        function void raise_rate(logic [BYTE_W-1:0] new_low);
            case (mode)
                M_DELAY, M_XY: begin
                    low = new_low;
                    if (low == 8'd0) begin
                        low = BYTE_MAX;
                        if (high != 8'd0) begin
                            high = high - 8'd1;
                        end else if (mode == M_DELAY) begin
                            mode = M_250K;
                        end else begin
                            // xy delay saturates at the shortest delay
                            low = 8'd1;
                        end
                    end
                end
                M_833K: mode = M_1M;
                M_625K: mode = M_833K;
                M_417K: mode = M_625K;
                M_250K: begin
                    mode = M_417K;
                    high = 8'd0;
                    low  = 8'd1;
                end
                default: ;
            endcase
        endfunction

        function void lower_rate(bit coarse);
            case (mode)
                M_DELAY, M_XY: begin
                    if (coarse ? (low < COARSE_LIM) : (low < BYTE_MAX)) begin
                        low = coarse ? (low << 1) : (low + 8'd1);
                    end else begin
                        low = 8'd1;
                        if (high < BYTE_MAX) high = high + 8'd1;
                    end
                end
                M_1M:   mode = M_833K;
                M_833K: mode = M_625K;
                M_625K: mode = M_417K;
                M_417K: mode = M_250K;
                M_250K: begin
                    mode = M_DELAY;
                    high = 8'd0;
                    low  = 8'd1;
                end
                default: ;
            endcase
        endfunction

        function int unsigned delay_ticks();
            int unsigned h;
            int unsigned l;
            h = high;
            l = low;
            // a zero low byte counts as a full 256, and a zero high byte as 255
            if (l == 0) begin
                if (h == 0) h = 255;
                l = 256;
            end
            return 5 + 7 * (h * 256 + l) + 3 * h;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [MODE_W-1:0] ld_mode,
                                   logic [BYTE_W-1:0] ld_high, logic [BYTE_W-1:0] ld_low);
            t_rate_result r;
            case (op)
                OP_CINC: raise_rate(low >> 1);
                OP_FINC: raise_rate(low - 8'd1);
                OP_CDEC: lower_rate(1'b1);
                OP_FDEC: lower_rate(1'b0);
                OP_LOAD: begin
                    mode = ld_mode;
                    high = ld_high;
                    low  = ld_low;
                end
                default: ;
            endcase
            r.mode  = mode;
            r.high  = high;
            r.low   = low;
            r.known = 1'b1;
            case (mode)
                M_DELAY: r.period = PERIOD_W'(delay_ticks() + 14);
                M_XY:    r.period = PERIOD_W'(delay_ticks() + 21);
                M_1M:    r.period = 19'd5;
                M_833K:  r.period = 19'd6;
                M_625K:  r.period = 19'd8;
                M_417K:  r.period = 19'd12;
                M_250K:  r.period = 19'd20;
                default: begin
                    r.period = 19'd0;
                    r.known  = 1'b0;
                end
            endcase
            expected_rates.push_back(r);
        endfunction

        function void check_result(t_rate_result got);
            t_rate_result exp_r;
            checked++;
            if (expected_rates.size() == 0) begin
                $error("result with no request pending: mode %0d high %0d low %0d",
                       got.mode, got.high, got.low);
                errors++;
                return;
            end
            exp_r = expected_rates.pop_front();
            if (got.mode !== exp_r.mode) begin
                $error("mode_now: expected %0d, got %0d", exp_r.mode, got.mode);
                errors++;
            end
            if (got.high !== exp_r.high) begin
                $error("high_now: expected %0d, got %0d", exp_r.high, got.high);
                errors++;
            end
            if (got.low !== exp_r.low) begin
                $error("low_now: expected %0d, got %0d", exp_r.low, got.low);
                errors++;
            end
            if (got.period !== exp_r.period) begin
                $error("period_ticks: expected %0d, got %0d", exp_r.period, got.period);
                errors++;
            end
            if (got.known !== exp_r.known) begin
                $error("mode_known: expected %0d, got %0d", exp_r.known, got.known);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic                o_ready;
    logic [OP_W-1:0]     i_opcode    = OP_NONE;
    logic [MODE_W-1:0]   i_load_mode = M_DELAY;
    logic [BYTE_W-1:0]   i_load_high = 8'd0;
    logic [BYTE_W-1:0]   i_load_low  = 8'd0;
    logic                o_valid;
    logic                i_ready     = 1'b0;
    logic [MODE_W-1:0]   o_mode_now;
    logic [BYTE_W-1:0]   o_high_now;
    logic [BYTE_W-1:0]   o_low_now;
    logic [PERIOD_W-1:0] o_period_ticks;
    logic                o_mode_known;

    rate_scoreboard sb = new();
    bit             reset_done = 1'b0;

    sample_rate_step_adjuster uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_load_mode    (i_load_mode),
        .i_load_high    (i_load_high),
        .i_load_low     (i_load_low),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_mode_now     (o_mode_now),
        .o_high_now     (o_high_now),
        .o_low_now      (o_low_now),
        .o_period_ticks (o_period_ticks),
        .o_mode_known   (o_mode_known)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Offer one request and hold it until accepted.
    task automatic send_request(logic [OP_W-1:0] op, logic [MODE_W-1:0] ld_mode,
                                logic [BYTE_W-1:0] ld_high, logic [BYTE_W-1:0] ld_low);
        i_valid     <= 1'b1;
        i_opcode    <= op;
        i_load_mode <= ld_mode;
        i_load_high <= ld_high;
        i_load_low  <= ld_low;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(op, ld_mode, ld_high, ld_low);
    endtask

    task automatic idle_sender(bit quiet);
        while (!quiet && $urandom_range(99) < 10) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte(bit low_side);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) return 8'd0;
        if (r < 30) return 8'd255;
        if (low_side && r < 40) return 8'd1;
        if (low_side && r < 45) return 8'd127;
        if (low_side && r < 50) return 8'd128;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_random(bit quiet);
        int unsigned       r;
        logic [OP_W-1:0]   op;
        logic [MODE_W-1:0] ld_mode;
        r = $urandom_range(99);
        // loads often enough to land near every range boundary
        if (r < 25) op = OP_LOAD;
        else        op = 3'($urandom_range(7));
        ld_mode = ($urandom_range(99) < 80) ? 4'($urandom_range(6)) : 4'($urandom_range(15));
        idle_sender(quiet);
        send_request(op, ld_mode, pick_byte(1'b0), pick_byte(1'b1));
    endtask

    // Sender
    initial begin
        @(posedge i_clk);
        @(posedge i_clk);
        i_rst_n <= 1'b1;
        reset_done = 1'b1;
        @(posedge i_clk);

        send_request(OP_NONE, M_DELAY, 8'h00, 8'h00);
        // fine increase out of the shortest delay goes to 250K
        send_request(OP_FINC, M_DELAY, 8'h00, 8'h00);
        send_request(OP_CINC, M_DELAY, 8'h00, 8'h00);
        send_request(OP_CINC, M_DELAY, 8'h00, 8'h00);
        send_request(OP_FINC, M_DELAY, 8'h00, 8'h00);
        send_request(OP_CINC, M_DELAY, 8'h00, 8'h00);
        send_request(OP_FINC, M_DELAY, 8'h00, 8'h00);
        send_request(OP_CDEC, M_DELAY, 8'h00, 8'h00);
        send_request(OP_FDEC, M_DELAY, 8'h00, 8'h00);
        send_request(OP_CDEC, M_DELAY, 8'h00, 8'h00);
        send_request(OP_FDEC, M_DELAY, 8'h00, 8'h00);
        send_request(OP_CDEC, M_DELAY, 8'h00, 8'h00);
        // xy delay saturates at the short end
        send_request(OP_LOAD, M_XY, 8'h00, 8'h01);
        send_request(OP_FINC, M_DELAY, 8'h00, 8'h00);
        // low byte of zero: fine increase wraps, coarse decrease holds
        send_request(OP_LOAD, M_DELAY, 8'h12, 8'h00);
        send_request(OP_FINC, M_DELAY, 8'h00, 8'h00);
        send_request(OP_LOAD, M_XY, 8'hff, 8'h00);
        send_request(OP_CDEC, M_DELAY, 8'h00, 8'h00);
        send_request(OP_LOAD, M_DELAY, 8'hff, 8'hff);
        send_request(OP_FDEC, M_DELAY, 8'h00, 8'h00);
        send_request(OP_LOAD, M_DELAY, 8'h00, 8'h00);
        send_request(OP_LOAD, 4'hf, 8'haa, 8'h55);
        send_request(3'd6, 4'h0, 8'h55, 8'haa);
        send_request(3'd7, 4'hf, 8'hff, 8'hff);
        send_request(OP_CINC, M_DELAY, 8'h00, 8'h00);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 1200) begin
                // let the pipeline run dry before going on
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending() != 0) @(posedge i_clk);
            end
            send_random(i >= 300 && i < 700);
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Receiver
    initial begin
        t_rate_result got;
        int           hold_left;
        bit           hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (reset_done && o_valid && i_ready) begin
                got.mode   = o_mode_now;
                got.high   = o_high_now;
                got.low    = o_low_now;
                got.period = o_period_ticks;
                got.known  = o_mode_known;
                sb.check_result(got);
            end
            if (!hold_done && sb.checked >= 900) begin
                // back up the pipeline while the sender keeps pushing
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (!reset_done) begin
                i_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (sb.checked >= 1400 && sb.checked < 1750) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= 10);
            end
        end
    end

endmodule
